// ----- rtl/expression_char_tokenizer_defines.svh -----
// Assertion macros shared by the tokenizer checker.
`ifndef EXPRESSION_CHAR_TOKENIZER_DEFINES_SVH
`define EXPRESSION_CHAR_TOKENIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, held off while rst_ni is low.
`define ECT_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, held off while rst_ni is low.
`define ECT_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/ect_pkg.sv -----
// Shared types and constants for the expression tokenizer.
package ect_pkg;

  localparam int unsigned POS_WIDTH_DEF = 16;
  localparam int unsigned FIELD_W       = 16;

  typedef enum logic [3:0] {
    K_LPAREN = 4'd0,
    K_RPAREN = 4'd1,
    K_PLUS   = 4'd2,
    K_MINUS  = 4'd3,
    K_MUL    = 4'd4,
    K_DIV    = 4'd5,
    K_CONST  = 4'd6,
    K_SIN    = 4'd7,
    K_COS    = 4'd8,
    K_IDENT  = 4'd9,
    K_END    = 4'd10,
    K_ERROR  = 4'd11
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] len;
  } tok_t;

  // Up to three tokens caused by one input byte.
  typedef struct packed {
    logic [1:0]       cnt;
    tok_t [2:0]       tok;
  } bundle_t;

endpackage

// ----- rtl/ect_lex.sv -----
// Scan state and per-byte token decode for the expression tokenizer.
module ect_lex #(
  parameter int unsigned POS_WIDTH = ect_pkg::POS_WIDTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      char_i,
  input  logic            last_i,
  output ect_pkg::bundle_t bundle_o
);

  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_INT   = 3'd1;
  localparam logic [2:0] M_DOT   = 3'd2;
  localparam logic [2:0] M_FRAC  = 3'd3;
  localparam logic [2:0] M_IDENT = 3'd4;
  localparam logic [2:0] M_ERROR = 3'd5;

  localparam logic [2:0] KW_NONE = 3'd0;
  localparam logic [2:0] KW_S    = 3'd1;
  localparam logic [2:0] KW_SI   = 3'd2;
  localparam logic [2:0] KW_SIN  = 3'd3;
  localparam logic [2:0] KW_C    = 3'd4;
  localparam logic [2:0] KW_CO   = 3'd5;
  localparam logic [2:0] KW_COS  = 3'd6;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_LO_S   = 8'h73;
  localparam logic [7:0] CH_LO_C   = 8'h63;
  localparam logic [7:0] CH_LO_I   = 8'h69;
  localparam logic [7:0] CH_LO_N   = 8'h6E;
  localparam logic [7:0] CH_LO_O   = 8'h6F;

  localparam logic [POS_WIDTH-1:0] POS_ONE = POS_WIDTH'(1);
  localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

  logic [2:0]           mode_q, mode_d;
  logic [POS_WIDTH-1:0] pos_q, pos_d;
  logic [POS_WIDTH-1:0] tb_q, tb_d;
  logic [2:0]           kw_q, kw_d;

  logic [POS_WIDTH-1:0] p, nxt, dot_pos;
  logic                 is_digit, is_alpha, do_start;
  ect_pkg::kind_e       sk, wk;
  logic                 s_emit;
  logic [1:0]           n;
  ect_pkg::kind_e       r_kind [3];
  logic [POS_WIDTH-1:0] r_start [3];
  logic [POS_WIDTH-1:0] r_len [3];

  function automatic logic [POS_WIDTH-1:0] span(input logic [POS_WIDTH-1:0] e,
                                                input logic [POS_WIDTH-1:0] b);
    span = (e > b) ? e - b : '0;
  endfunction

  function automatic logic [ect_pkg::FIELD_W-1:0] clamp(input logic [POS_WIDTH-1:0] v);
    logic [31:0] w;
    w     = 32'(v);
    clamp = (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  assign p        = pos_q;
  assign nxt      = (pos_q != POS_MAX) ? pos_q + POS_ONE : pos_q;
  assign dot_pos  = (pos_q != '0) ? pos_q - POS_ONE : '0;
  assign is_digit = (char_i >= 8'h30) && (char_i <= 8'h39);
  assign is_alpha = ((char_i >= 8'h61) && (char_i <= 8'h7A)) ||
                    ((char_i >= 8'h41) && (char_i <= 8'h5A));

  // Single-byte tokens
  always_comb begin
    s_emit = 1'b1;
    sk     = ect_pkg::K_ERROR;
    case (char_i)
      CH_LPAREN: sk = ect_pkg::K_LPAREN;
      CH_RPAREN: sk = ect_pkg::K_RPAREN;
      CH_PLUS:   sk = ect_pkg::K_PLUS;
      CH_MINUS:  sk = ect_pkg::K_MINUS;
      CH_MUL:    sk = ect_pkg::K_MUL;
      CH_DIV:    sk = ect_pkg::K_DIV;
      CH_SP, CH_TAB, CH_CR, CH_LF: s_emit = 1'b0;
      default:   s_emit = !(is_digit || is_alpha);
    endcase
  end

  always_comb begin
    mode_d   = mode_q;
    tb_d     = tb_q;
    kw_d     = kw_q;
    pos_d    = nxt;
    n        = 2'd0;
    do_start = 1'b0;
    wk       = ect_pkg::K_CONST;
    for (int i = 0; i < 3; i++) begin
      r_kind[i]  = ect_pkg::K_END;
      r_start[i] = '0;
      r_len[i]   = '0;
    end

    // Word closed by this byte
    if (mode_q == M_IDENT) begin
      wk = (kw_q == KW_SIN) ? ect_pkg::K_SIN :
           (kw_q == KW_COS) ? ect_pkg::K_COS : ect_pkg::K_IDENT;
    end

    case (mode_q)
      M_IDENT: begin
        if (is_alpha || is_digit) begin
          if      (kw_q == KW_S  && char_i == CH_LO_I) kw_d = KW_SI;
          else if (kw_q == KW_SI && char_i == CH_LO_N) kw_d = KW_SIN;
          else if (kw_q == KW_C  && char_i == CH_LO_O) kw_d = KW_CO;
          else if (kw_q == KW_CO && char_i == CH_LO_S) kw_d = KW_COS;
          else                                         kw_d = KW_NONE;
        end else begin
          r_kind[n] = wk; r_start[n] = tb_q; r_len[n] = span(p, tb_q);
          n = n + 2'd1;
          mode_d   = M_IDLE;
          do_start = 1'b1;
        end
      end
      M_INT, M_FRAC: begin
        if (mode_q == M_INT && char_i == CH_DOT) begin
          mode_d = M_DOT;
        end else if (!is_digit) begin
          r_kind[n] = ect_pkg::K_CONST; r_start[n] = tb_q; r_len[n] = span(p, tb_q);
          n = n + 2'd1;
          mode_d   = M_IDLE;
          do_start = 1'b1;
        end
      end
      M_DOT: begin
        if (is_digit) begin
          mode_d = M_FRAC;
        end else begin
          // digits before the dot form a constant; the dot itself is the error
          r_kind[n] = ect_pkg::K_CONST; r_start[n] = tb_q; r_len[n] = span(dot_pos, tb_q);
          n = n + 2'd1;
          r_kind[n] = ect_pkg::K_ERROR; r_start[n] = dot_pos; r_len[n] = POS_ONE;
          n = n + 2'd1;
          mode_d = M_ERROR;
        end
      end
      M_ERROR: ;
      default: begin
        mode_d   = M_IDLE;
        do_start = 1'b1;
      end
    endcase

    if (do_start) begin
      if (s_emit) begin
        r_kind[n] = sk; r_start[n] = p; r_len[n] = POS_ONE;
        n = n + 2'd1;
        if (sk == ect_pkg::K_ERROR) mode_d = M_ERROR;
      end else if (is_digit) begin
        mode_d = M_INT;
        tb_d   = p;
      end else if (is_alpha) begin
        mode_d = M_IDENT;
        tb_d   = p;
        kw_d   = (char_i == CH_LO_S) ? KW_S : (char_i == CH_LO_C) ? KW_C : KW_NONE;
      end
    end

    if (last_i) begin
      if (mode_d == M_DOT) begin
        r_kind[n] = ect_pkg::K_CONST; r_start[n] = tb_d; r_len[n] = span(p, tb_d);
        n = n + 2'd1;
        r_kind[n] = ect_pkg::K_ERROR; r_start[n] = p; r_len[n] = POS_ONE;
        n = n + 2'd1;
      end else if (mode_d == M_INT || mode_d == M_FRAC || mode_d == M_IDENT) begin
        r_kind[n] = ect_pkg::K_CONST;
        if (mode_d == M_IDENT) begin
          r_kind[n] = (kw_d == KW_SIN) ? ect_pkg::K_SIN :
                      (kw_d == KW_COS) ? ect_pkg::K_COS : ect_pkg::K_IDENT;
        end
        r_start[n] = tb_d; r_len[n] = span(nxt, tb_d);
        n = n + 2'd1;
      end
      if (mode_d != M_ERROR && mode_d != M_DOT) begin
        r_kind[n] = ect_pkg::K_END; r_start[n] = nxt; r_len[n] = '0;
        n = n + 2'd1;
      end
      mode_d = M_IDLE;
      pos_d  = '0;
      tb_d   = '0;
      kw_d   = KW_NONE;
    end
  end

  always_comb begin
    bundle_o.cnt = n;
    for (int i = 0; i < 3; i++) begin
      bundle_o.tok[i].kind  = r_kind[i];
      bundle_o.tok[i].start = clamp(r_start[i]);
      bundle_o.tok[i].len   = clamp(r_len[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      pos_q  <= '0;
      tb_q   <= '0;
      kw_q   <= KW_NONE;
    end else if (step_i) begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      tb_q   <= tb_d;
      kw_q   <= kw_d;
    end
  end

endmodule

// ----- rtl/expression_char_tokenizer.sv -----
// Streaming lexer for arithmetic expressions, one byte per input beat.
//
// Input channel: char_code_i / end_of_text_i with in_valid_i / in_stall_o.
// Output channel: one token per beat (kind, start, length, last_of_run_o)
// with out_valid_o / out_stall_i. last_of_run_o marks the final token caused
// by one input byte; a byte may cause zero to three tokens.
// A byte is held in the input register, then its tokens in the token register
// that feeds the outputs.
// Throughput: one byte per cycle while each byte yields at most one token
// and the output is not stalled. A byte with two or three tokens holds the
// token register until its last token has left; the input stalls meanwhile.
// A stalled output keeps its beat unchanged; once the token register and the
// input register are both occupied, in_stall_o rises.
// Reset clears the scan mode, position, token start and both valid flags;
// the next byte taken is position zero of a new expression.
// A byte flagged end_of_text_i also returns the scanner to that state.
module expression_char_tokenizer #(
  parameter int unsigned POS_WIDTH = ect_pkg::POS_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  token_kind_o,
  output logic [15:0] token_start_o,
  output logic [15:0] token_length_o,
  output logic        last_of_run_o
);

  logic             a_vld_q, a_vld_d;
  logic [7:0]       a_char_q;
  logic             a_last_q;
  logic [1:0]       b_cnt_q, b_cnt_d;
  logic [1:0]       b_idx_q, b_idx_d;
  ect_pkg::tok_t [2:0] b_tok_q;
  ect_pkg::tok_t    cur;
  ect_pkg::bundle_t bundle;
  logic             in_fire, out_fire, out_last, b_free, adv;

  ect_lex #(
    .POS_WIDTH(POS_WIDTH)
  ) u_lex (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .char_i   (a_char_q),
    .last_i   (a_last_q),
    .bundle_o (bundle)
  );

  assign cur      = b_tok_q[b_idx_q];
  assign out_last = (b_idx_q == (b_cnt_q - 2'd1));

  assign out_valid_o    = (b_cnt_q != 2'd0);
  assign token_kind_o   = cur.kind;
  assign token_start_o  = cur.start;
  assign token_length_o = cur.len;
  assign last_of_run_o  = out_last;

  assign out_fire   = out_valid_o && !out_stall_i;
  assign b_free     = (b_cnt_q == 2'd0) || (out_fire && out_last);
  assign adv        = a_vld_q && b_free;
  assign in_stall_o = a_vld_q && !adv;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    a_vld_d = a_vld_q;
    if (in_fire)  a_vld_d = 1'b1;
    else if (adv) a_vld_d = 1'b0;

    b_cnt_d = b_cnt_q;
    b_idx_d = b_idx_q;
    if (adv) begin
      b_cnt_d = bundle.cnt;
      b_idx_d = 2'd0;
    end else if (out_fire) begin
      if (out_last) b_cnt_d = 2'd0;
      else          b_idx_d = b_idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_cnt_q <= 2'd0;
      b_idx_q <= 2'd0;
    end else begin
      a_vld_q <= a_vld_d;
      b_cnt_q <= b_cnt_d;
      b_idx_q <= b_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_char_q <= char_code_i;
      a_last_q <= end_of_text_i;
    end
    if (adv) begin
      b_tok_q <= bundle.tok;
    end
  end

endmodule

// ----- rtl/ect_checker.sv -----
// Port-level checks for the expression tokenizer, bound to the top level.
`include "expression_char_tokenizer_defines.svh"

module ect_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  token_kind_o,
  input logic [15:0] token_start_o,
  input logic [15:0] token_length_o,
  input logic        last_of_run_o
);

  // A stalled output beat holds.
  `ECT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                   out_valid_o && $stable(token_kind_o) && $stable(token_start_o) &&
                   $stable(token_length_o) && $stable(last_of_run_o),
                   "stalled output beat changed")

  // End token: empty lexeme, closes the run.
  `ECT_ASSERT_IMPL(a_end_shape, out_valid_o && token_kind_o == ect_pkg::K_END,
                   token_length_o == 16'd0 && last_of_run_o, "malformed end token")

  // Error token: one byte, nothing follows it from the same byte.
  `ECT_ASSERT_IMPL(a_err_shape, out_valid_o && token_kind_o == ect_pkg::K_ERROR,
                   token_length_o == 16'd1 && last_of_run_o, "malformed error token")

  // Parentheses and operators are one byte long.
  `ECT_ASSERT_IMPL(a_punct_len, out_valid_o && token_kind_o <= ect_pkg::K_DIV,
                   token_length_o == 16'd1, "punctuation length not one")

endmodule

bind expression_char_tokenizer ect_checker u_ect_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .token_kind_o   (token_kind_o),
  .token_start_o  (token_start_o),
  .token_length_o (token_length_o),
  .last_of_run_o  (last_of_run_o)
);
